// ===== rtl/assert_macros.svh =====
// Assertion helpers. Each expects clk and rst in the scope of the use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/ptcp_pkg.sv =====
package ptcp_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int LIMB_W         = 32;
  localparam int IO_W           = 32;
  localparam int DIST_W         = 64;

  typedef logic [2:0] region_t;

  localparam region_t REG_VERT_A  = 3'd0;
  localparam region_t REG_VERT_B  = 3'd1;
  localparam region_t REG_EDGE_AB = 3'd2;
  localparam region_t REG_VERT_C  = 3'd3;
  localparam region_t REG_EDGE_AC = 3'd4;
  localparam region_t REG_EDGE_BC = 3'd5;
  localparam region_t REG_INSIDE  = 3'd6;

endpackage

// ===== rtl/ptcp_delay.sv =====
module ptcp_delay import ptcp_pkg::*; #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    sr[0] <= din;
    for (int k = 1; k < N; k++) begin
      sr[k] <= sr[k-1];
    end
  end

  assign dout = sr[N-1];

endmodule

// ===== rtl/ptcp_mul.sv =====
module ptcp_mul import ptcp_pkg::*; #(
  parameter int WA = 68,
  parameter int WB = 68
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    vin,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic                    vout,
  output logic signed [WA+WB-1:0] p
);

  localparam int PW = WA + WB;
  localparam int NA = (WA + LIMB_W - 1) / LIMB_W;
  localparam int NB = (WB + LIMB_W - 1) / LIMB_W;
  localparam int XW = (NA + NB) * LIMB_W;

  logic                     vld [NB+2];
  logic [NA*LIMB_W-1:0]     ma  [NB];
  logic [NB*LIMB_W-1:0]     mb  [NB];
  logic                     ng  [NB+1];
  logic [XW-1:0]            acc [NB];
  logic [WA-1:0]            abs_a;
  logic [WB-1:0]            abs_b;

  always_comb begin
    abs_a = a[WA-1] ? -a : a;
    abs_b = b[WB-1] ? -b : b;
  end

  // Magnitudes go in first; the sign is put back after the last row.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= vin;
    end
    ma[0] <= (NA*LIMB_W)'(abs_a);
    mb[0] <= (NB*LIMB_W)'(abs_b);
    ng[0] <= a[WA-1] ^ b[WB-1];
  end

  // One limb of b per stage, multiplied against every limb of a.
  for (genvar k = 0; k < NB; k++) begin : g_row
    logic [XW-1:0]         row;
    logic [2*LIMB_W-1:0]   pp;

    always_comb begin
      row = '0;
      pp  = '0;
      for (int i = 0; i < NA; i++) begin
        pp  = ma[k][i*LIMB_W +: LIMB_W] * mb[k][k*LIMB_W +: LIMB_W];
        row = row + (XW'(pp) << (LIMB_W * (i + k)));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      ng[k+1] <= ng[k];
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        acc[k] <= row;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        acc[k] <= acc[k-1] + row;
      end
    end

    if (k < NB - 1) begin : g_pass
      always_ff @(posedge clk) begin
        ma[k+1] <= ma[k];
        mb[k+1] <= mb[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[NB+1] <= 1'b0;
    end else begin
      vld[NB+1] <= vld[NB];
    end
    p <= ng[NB] ? -$signed(acc[NB-1][PW-1:0]) : $signed(acc[NB-1][PW-1:0]);
  end

  assign vout = vld[NB+1];

endmodule

// ===== rtl/ptcp_div.sv =====
module ptcp_div import ptcp_pkg::*; #(
  parameter int NW = 139,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vin,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic                 vout,
  output logic [FB:0]          q
);

  logic          vld  [FB+1];
  logic [NW-1:0] rem  [FB+1];
  logic [NW-1:0] dv   [FB+1];
  logic [FB-1:0] qb   [FB+1];
  logic          zro  [FB+1];
  logic          sat  [FB+1];
  logic          zro_in;

  // A fraction is zero for a non-positive divisor or a negative numerator,
  // and saturates at one when the numerator reaches the divisor.
  assign zro_in = den[NW-1] || (den == '0) || num[NW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= vin;
    end
    rem[0] <= num;
    dv[0]  <= den;
    qb[0]  <= '0;
    zro[0] <= zro_in;
    sat[0] <= !zro_in && (num >= den);
  end

  for (genvar k = 0; k < FB; k++) begin : g_step
    logic [NW:0] sh;
    logic [NW:0] df;
    logic        ge;

    always_comb begin
      sh = {rem[k], 1'b0};
      df = sh - {1'b0, dv[k]};
      ge = sh >= {1'b0, dv[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1] <= ge ? df[NW-1:0] : sh[NW-1:0];
      dv[k+1]  <= dv[k];
      qb[k+1]  <= {qb[k][FB-2:0], ge};
      zro[k+1] <= zro[k];
      sat[k+1] <= sat[k];
    end
  end

  always_comb begin
    if (zro[FB]) begin
      q = '0;
    end else if (sat[FB]) begin
      q = {1'b1, {FB{1'b0}}};
    end else begin
      q = {1'b0, qb[FB]};
    end
  end

  assign vout = vld[FB];

endmodule

// ===== rtl/point_triangle_closest_point_top.sv =====
// Throughput: one item per clock; the pipeline never stalls and busy is high only in reset.
// Depth is set by the limb-serial multipliers for the barycentric cross terms and by the
// restoring dividers, which take one quotient bit per stage.
// Synchronous reset clears the valid bits only; items in flight are dropped.
`include "assert_macros.svh"
module point_triangle_closest_point_top import ptcp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [IO_W-1:0]   point_x,
  input  logic signed [IO_W-1:0]   point_y,
  input  logic signed [IO_W-1:0]   point_z,
  input  logic signed [IO_W-1:0]   vert_a_x,
  input  logic signed [IO_W-1:0]   vert_a_y,
  input  logic signed [IO_W-1:0]   vert_a_z,
  input  logic signed [IO_W-1:0]   vert_b_x,
  input  logic signed [IO_W-1:0]   vert_b_y,
  input  logic signed [IO_W-1:0]   vert_b_z,
  input  logic signed [IO_W-1:0]   vert_c_x,
  input  logic signed [IO_W-1:0]   vert_c_y,
  input  logic signed [IO_W-1:0]   vert_c_z,
  output logic                     done,
  output logic signed [IO_W-1:0]   near_x,
  output logic signed [IO_W-1:0]   near_y,
  output logic signed [IO_W-1:0]   near_z,
  output logic [DIST_W-1:0]        dist_sq,
  output region_t                  region
);

  localparam int CB  = COORD_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int DFW = CB + 1;
  localparam int PRW = 2 * CB + 2;
  localparam int DW  = 2 * CB + 4;
  localparam int VW  = 2 * DW + 1;
  localparam int NW  = VW + 2;
  localparam int LM  = (DW + LIMB_W - 1) / LIMB_W + 2;
  localparam int DL  = FB + 1;
  localparam int SW  = FB + CB + 4;
  localparam int GW  = 12 * CB + 9 * DFW;
  localparam int PLW = 3 + 6 * CB + 6 * DFW;
  localparam int TW  = DIST_W + 2;

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // ---------------- stage 1: edge and offset vectors
  logic signed [CB-1:0]  pi [3], ai [3], bi [3], ci [3];
  logic signed [CB-1:0]  p1 [3], a1 [3], b1 [3], c1 [3];
  logic signed [DFW-1:0] ab1 [3], ac1 [3], bc1 [3], ap1 [3], bp1 [3], cp1 [3];
  logic v1;

  always_comb begin
    pi[0] = point_x[CB-1:0];  pi[1] = point_y[CB-1:0];  pi[2] = point_z[CB-1:0];
    ai[0] = vert_a_x[CB-1:0]; ai[1] = vert_a_y[CB-1:0]; ai[2] = vert_a_z[CB-1:0];
    bi[0] = vert_b_x[CB-1:0]; bi[1] = vert_b_y[CB-1:0]; bi[2] = vert_b_z[CB-1:0];
    ci[0] = vert_c_x[CB-1:0]; ci[1] = vert_c_y[CB-1:0]; ci[2] = vert_c_z[CB-1:0];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p1[i]  <= pi[i];
      a1[i]  <= ai[i];
      b1[i]  <= bi[i];
      c1[i]  <= ci[i];
      ab1[i] <= DFW'(bi[i]) - DFW'(ai[i]);
      ac1[i] <= DFW'(ci[i]) - DFW'(ai[i]);
      bc1[i] <= DFW'(ci[i]) - DFW'(bi[i]);
      ap1[i] <= DFW'(pi[i]) - DFW'(ai[i]);
      bp1[i] <= DFW'(pi[i]) - DFW'(bi[i]);
      cp1[i] <= DFW'(pi[i]) - DFW'(ci[i]);
    end
  end

  // ---------------- stage 2: coordinate products of the six dot products
  logic signed [PRW-1:0] pr2 [6][3];
  logic v2;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pr2[0][i] <= ab1[i] * ap1[i];
      pr2[1][i] <= ac1[i] * ap1[i];
      pr2[2][i] <= ab1[i] * bp1[i];
      pr2[3][i] <= ac1[i] * bp1[i];
      pr2[4][i] <= ab1[i] * cp1[i];
      pr2[5][i] <= ac1[i] * cp1[i];
    end
  end

  // ---------------- stage 3: d1 .. d6
  logic signed [DW-1:0] dd3 [6];
  logic v3;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 6; j++) begin
      dd3[j] <= DW'(pr2[j][0]) + DW'(pr2[j][1]) + DW'(pr2[j][2]);
    end
  end

  // Geometry rides alongside until the region is known.
  logic [GW-1:0] g_in, g_out;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_in[i*CB +: CB]                 = p1[i];
      g_in[(3+i)*CB +: CB]             = a1[i];
      g_in[(6+i)*CB +: CB]             = b1[i];
      g_in[(9+i)*CB +: CB]             = c1[i];
      g_in[12*CB + i*DFW +: DFW]       = ab1[i];
      g_in[12*CB + (3+i)*DFW +: DFW]   = ac1[i];
      g_in[12*CB + (6+i)*DFW +: DFW]   = bc1[i];
    end
  end

  ptcp_delay #(.W(GW), .N(LM + 4)) u_geo_dly (
    .clk  (clk),
    .din  (g_in),
    .dout (g_out)
  );

  // ---------------- cross terms of the barycentric coordinates
  logic signed [DW-1:0]   opa [6], opb [6];
  logic signed [2*DW-1:0] mp  [6];
  logic                   mv  [6];

  always_comb begin
    opa[0] = dd3[0]; opb[0] = dd3[3];
    opa[1] = dd3[2]; opb[1] = dd3[1];
    opa[2] = dd3[4]; opb[2] = dd3[1];
    opa[3] = dd3[0]; opb[3] = dd3[5];
    opa[4] = dd3[2]; opb[4] = dd3[5];
    opa[5] = dd3[4]; opb[5] = dd3[3];
  end

  for (genvar j = 0; j < 6; j++) begin : g_mul
    ptcp_mul #(.WA(DW), .WB(DW)) u_mul (
      .clk  (clk),
      .rst  (rst),
      .vin  (v3),
      .a    (opa[j]),
      .b    (opb[j]),
      .vout (mv[j]),
      .p    (mp[j])
    );
  end

  logic [6*DW-1:0] dd_in, dd_out;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      dd_in[j*DW +: DW] = dd3[j];
    end
  end

  ptcp_delay #(.W(6*DW), .N(LM)) u_dd_dly (
    .clk  (clk),
    .din  (dd_in),
    .dout (dd_out)
  );

  // ---------------- stage V: va, vb, vc
  logic signed [VW-1:0] vaV, vbV, vcV;
  logic signed [DW-1:0] ddV [6];
  logic vV;

  always_ff @(posedge clk) begin
    vcV <= VW'(mp[0]) - VW'(mp[1]);
    vbV <= VW'(mp[2]) - VW'(mp[3]);
    vaV <= VW'(mp[4]) - VW'(mp[5]);
    for (int j = 0; j < 6; j++) begin
      ddV[j] <= $signed(dd_out[j*DW +: DW]);
    end
  end

  // ---------------- stage S: differences and the interior divisor
  logic signed [VW-1:0]   vaS, vbS, vcS;
  logic signed [DW-1:0]   ddS [6];
  logic signed [DW:0]     n13S, n26S, n43S, n56S;
  logic signed [DW+1:0]   n5sS;
  logic signed [NW-1:0]   denS;
  logic vS;

  always_ff @(posedge clk) begin
    vaS  <= vaV;
    vbS  <= vbV;
    vcS  <= vcV;
    for (int j = 0; j < 6; j++) begin
      ddS[j] <= ddV[j];
    end
    n13S <= (DW+1)'(ddV[0]) - (DW+1)'(ddV[2]);
    n26S <= (DW+1)'(ddV[1]) - (DW+1)'(ddV[5]);
    n43S <= (DW+1)'(ddV[3]) - (DW+1)'(ddV[2]);
    n56S <= (DW+1)'(ddV[4]) - (DW+1)'(ddV[5]);
    n5sS <= (DW+2)'(ddV[3]) - (DW+2)'(ddV[2]) + (DW+2)'(ddV[4]) - (DW+2)'(ddV[5]);
    denS <= NW'(vaV) + NW'(vbV) + NW'(vcV);
  end

  // ---------------- stage R: region and divider operands
  logic signed [CB-1:0]  pg [3], ag [3], bg [3], cg [3];
  logic signed [DFW-1:0] abg [3], acg [3], bcg [3];
  logic le1, le2, le3, le6, ge1, ge2, ge3, ge6;
  logic le43, ge43, le56, ge56, leva, levb, levc;
  region_t              rg_n;
  logic signed [NW-1:0] num1_n, den1_n, num2_n, den2_n;
  logic signed [CB-1:0]  base_n [3];
  logic signed [DFW-1:0] e1_n [3], e2_n [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pg[i]  = $signed(g_out[i*CB +: CB]);
      ag[i]  = $signed(g_out[(3+i)*CB +: CB]);
      bg[i]  = $signed(g_out[(6+i)*CB +: CB]);
      cg[i]  = $signed(g_out[(9+i)*CB +: CB]);
      abg[i] = $signed(g_out[12*CB + i*DFW +: DFW]);
      acg[i] = $signed(g_out[12*CB + (3+i)*DFW +: DFW]);
      bcg[i] = $signed(g_out[12*CB + (6+i)*DFW +: DFW]);
    end
  end

  always_comb begin
    le1  = ddS[0][DW-1] || (ddS[0] == '0);
    le2  = ddS[1][DW-1] || (ddS[1] == '0);
    le3  = ddS[2][DW-1] || (ddS[2] == '0);
    le6  = ddS[5][DW-1] || (ddS[5] == '0);
    ge1  = !ddS[0][DW-1];
    ge2  = !ddS[1][DW-1];
    ge3  = !ddS[2][DW-1];
    ge6  = !ddS[5][DW-1];
    le43 = n43S[DW] || (n43S == '0);
    ge43 = !n43S[DW];
    le56 = n56S[DW] || (n56S == '0);
    ge56 = !n56S[DW];
    leva = vaS[VW-1] || (vaS == '0);
    levb = vbS[VW-1] || (vbS == '0);
    levc = vcS[VW-1] || (vcS == '0);

    // Vertex regions and a degenerate triangle leave both fractions at zero.
    rg_n   = REG_VERT_A;
    num1_n = '0;
    den1_n = '0;
    num2_n = '0;
    den2_n = '0;
    for (int i = 0; i < 3; i++) begin
      base_n[i] = ag[i];
      e1_n[i]   = '0;
      e2_n[i]   = '0;
    end

    if (le1 && le2) begin
      rg_n = REG_VERT_A;
    end else if (ge3 && le43) begin
      rg_n = REG_VERT_B;
      for (int i = 0; i < 3; i++) base_n[i] = bg[i];
    end else if (levc && ge1 && le3) begin
      rg_n   = REG_EDGE_AB;
      num1_n = NW'(ddS[0]);
      den1_n = NW'(n13S);
      for (int i = 0; i < 3; i++) e1_n[i] = abg[i];
    end else if (ge6 && le56) begin
      rg_n = REG_VERT_C;
      for (int i = 0; i < 3; i++) base_n[i] = cg[i];
    end else if (levb && ge2 && le6) begin
      rg_n   = REG_EDGE_AC;
      num1_n = NW'(ddS[1]);
      den1_n = NW'(n26S);
      for (int i = 0; i < 3; i++) e1_n[i] = acg[i];
    end else if (leva && ge43 && ge56) begin
      rg_n   = REG_EDGE_BC;
      num1_n = NW'(n43S);
      den1_n = NW'(n5sS);
      for (int i = 0; i < 3; i++) begin
        base_n[i] = bg[i];
        e1_n[i]   = bcg[i];
      end
    end else if (denS != '0) begin
      rg_n   = REG_INSIDE;
      num1_n = NW'(vbS);
      den1_n = denS;
      num2_n = NW'(vcS);
      den2_n = denS;
      for (int i = 0; i < 3; i++) begin
        e1_n[i] = abg[i];
        e2_n[i] = acg[i];
      end
    end
  end

  region_t              rgR;
  logic signed [NW-1:0] num1R, den1R, num2R, den2R;
  logic signed [CB-1:0]  baseR [3], pR [3];
  logic signed [DFW-1:0] e1R [3], e2R [3];
  logic vR;

  always_ff @(posedge clk) begin
    rgR   <= rg_n;
    num1R <= num1_n;
    den1R <= den1_n;
    num2R <= num2_n;
    den2R <= den2_n;
    for (int i = 0; i < 3; i++) begin
      baseR[i] <= base_n[i];
      pR[i]    <= pg[i];
      e1R[i]   <= e1_n[i];
      e2R[i]   <= e2_n[i];
    end
  end

  // ---------------- fractions
  logic [FB:0] t1, t2;
  logic        vdiv, vdiv2;

  ptcp_div #(.NW(NW), .FB(FB)) u_div1 (
    .clk  (clk),
    .rst  (rst),
    .vin  (vR),
    .num  (num1R),
    .den  (den1R),
    .vout (vdiv),
    .q    (t1)
  );

  ptcp_div #(.NW(NW), .FB(FB)) u_div2 (
    .clk  (clk),
    .rst  (rst),
    .vin  (vR),
    .num  (num2R),
    .den  (den2R),
    .vout (vdiv2),
    .q    (t2)
  );

  logic [PLW-1:0] pl_in, pl_out;

  always_comb begin
    pl_in[2:0] = rgR;
    for (int i = 0; i < 3; i++) begin
      pl_in[3 + i*CB +: CB]                  = baseR[i];
      pl_in[3 + (3+i)*CB +: CB]              = pR[i];
      pl_in[3 + 6*CB + i*DFW +: DFW]         = e1R[i];
      pl_in[3 + 6*CB + (3+i)*DFW +: DFW]     = e2R[i];
    end
  end

  ptcp_delay #(.W(PLW), .N(DL)) u_pl_dly (
    .clk  (clk),
    .din  (pl_in),
    .dout (pl_out)
  );

  // ---------------- stage N1: fraction times edge vectors
  logic signed [FB+1:0]  t1s, t2s;
  logic signed [SW-1:0]  sN1 [3];
  logic signed [CB-1:0]  baseN1 [3], pN1 [3];
  region_t               rgN1;
  logic vN1;

  assign t1s = {1'b0, t1};
  assign t2s = {1'b0, t2};

  always_ff @(posedge clk) begin
    rgN1 <= pl_out[2:0];
    for (int i = 0; i < 3; i++) begin
      baseN1[i] <= $signed(pl_out[3 + i*CB +: CB]);
      pN1[i]    <= $signed(pl_out[3 + (3+i)*CB +: CB]);
      sN1[i]    <= SW'(t1s) * SW'($signed(pl_out[3 + 6*CB + i*DFW +: DFW]))
                 + SW'(t2s) * SW'($signed(pl_out[3 + 6*CB + (3+i)*DFW +: DFW]));
    end
  end

  // ---------------- stage N2: offset from the base vertex, clamped
  logic signed [CB+4:0] qt [3];
  logic [CB-1:0]        qc [3];
  logic signed [CB-1:0] qN2 [3], pN2 [3];
  region_t              rgN2;
  logic vN2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qt[i] = (CB+5)'(baseN1[i]) + (CB+5)'(sN1[i] >>> FB);
      if ((qt[i][CB+4:CB-1] != '0) && (qt[i][CB+4:CB-1] != '1)) begin
        qc[i] = qt[i][CB+4] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
      end else begin
        qc[i] = qt[i][CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rgN2 <= rgN1;
    for (int i = 0; i < 3; i++) begin
      qN2[i] <= qc[i];
      pN2[i] <= pN1[i];
    end
  end

  // ---------------- stage N3: distance magnitudes
  logic signed [DFW-1:0] dt [3];
  logic [CB-1:0]         mN3 [3];
  logic signed [CB-1:0]  qN3 [3];
  region_t               rgN3;
  logic vN3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dt[i] = DFW'(pN2[i]) - DFW'(qN2[i]);
    end
  end

  always_ff @(posedge clk) begin
    rgN3 <= rgN2;
    for (int i = 0; i < 3; i++) begin
      mN3[i] <= dt[i][DFW-1] ? CB'(-dt[i]) : CB'(dt[i]);
      qN3[i] <= qN2[i];
    end
  end

  // ---------------- stage N4: squares
  logic [2*CB-1:0]      sqN4 [3];
  logic signed [CB-1:0] qN4 [3];
  region_t              rgN4;
  logic vN4;

  always_ff @(posedge clk) begin
    rgN4 <= rgN3;
    for (int i = 0; i < 3; i++) begin
      sqN4[i] <= mN3[i] * mN3[i];
      qN4[i]  <= qN3[i];
    end
  end

  // ---------------- stage N5: saturating sum and result registers
  logic [TW-1:0] tot;

  assign tot = TW'(sqN4[0]) + TW'(sqN4[1]) + TW'(sqN4[2]);

  always_ff @(posedge clk) begin
    near_x  <= IO_W'(qN4[0]);
    near_y  <= IO_W'(qN4[1]);
    near_z  <= IO_W'(qN4[2]);
    dist_sq <= (tot[TW-1:DIST_W] != '0) ? {DIST_W{1'b1}} : tot[DIST_W-1:0];
    region  <= rgN4;
  end

  // Valid bits, one per stage outside the multiplier and divider units.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      vV   <= 1'b0;
      vS   <= 1'b0;
      vR   <= 1'b0;
      vN1  <= 1'b0;
      vN2  <= 1'b0;
      vN3  <= 1'b0;
      vN4  <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      vV   <= mv[0];
      vS   <= vV;
      vR   <= vS;
      vN1  <= vdiv;
      vN2  <= vN1;
      vN3  <= vN2;
      vN4  <= vN3;
      done <= vN4;
    end
  end

  `ASSERT_NEXT(a_accept_enters, accept, v1)
  `ASSERT_IMP(a_div_in_step, vdiv, vdiv2)
  `ASSERT_IMP(a_vertex_no_frac, vR && (rgR == REG_VERT_A || rgR == REG_VERT_B || rgR == REG_VERT_C), num1R == '0 && num2R == '0)
  `ASSERT_IMP(a_w_only_inside, vR && rgR != REG_INSIDE, num2R == '0)
  `ASSERT_IMP(a_region_code, done, region <= REG_INSIDE)

endmodule
